[sv/etok_pkg.sv]
// shared types, character codes and classifier functions for the expression tokenizer
// no dependencies; used by etok_step and expression_tokenizer

package etok_pkg;

    localparam int MAX_LEN_DEF = 64;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // token types
    localparam logic [3:0] TT_INVALID = 4'd0;
    localparam logic [3:0] TT_INT     = 4'd1;
    localparam logic [3:0] TT_FLOAT   = 4'd2;
    localparam logic [3:0] TT_IDENT   = 4'd3;
    localparam logic [3:0] TT_PLUS    = 4'd4;
    localparam logic [3:0] TT_MINUS   = 4'd5;
    localparam logic [3:0] TT_MUL     = 4'd6;
    localparam logic [3:0] TT_DIV     = 4'd7;
    localparam logic [3:0] TT_OPEN    = 4'd8;
    localparam logic [3:0] TT_CLOSE   = 4'd9;
    localparam logic [3:0] TT_SEMI    = 4'd10;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT
    } mode_t;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_END,
        KIND_EOI
    } kind_t;

    // one result word, without the last flag
    typedef struct packed {
        kind_t      kind;
        logic [3:0] token_type;
        logic [7:0] char_value;
        logic [5:0] char_index;
        logic       too_long;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic [3:0] op_type(input logic [7:0] c);
        case (c)
            CH_PLUS:  op_type = TT_PLUS;
            CH_MINUS: op_type = TT_MINUS;
            CH_STAR:  op_type = TT_MUL;
            CH_SLASH: op_type = TT_DIV;
            CH_OPEN:  op_type = TT_OPEN;
            CH_CLOSE: op_type = TT_CLOSE;
            CH_SEMI:  op_type = TT_SEMI;
            default:  op_type = TT_INVALID;
        endcase
    endfunction

endpackage

[sv/etok_step.sv]
// combinational lexer step: one byte plus token state gives up to three result words
// and the next token state; depends on etok_pkg

module etok_step #(
    parameter int MAX_LEN = etok_pkg::MAX_LEN_DEF,
    localparam int LW = $clog2(MAX_LEN)
) (
    input  logic [7:0]              char_byte,
    input  etok_pkg::mode_t         mode,
    input  logic [LW-1:0]           len,
    input  logic                    dot,
    input  logic                    ovf,
    output etok_pkg::result_t       res [3],
    output logic [1:0]              count,
    output etok_pkg::mode_t         mode_next,
    output logic [LW-1:0]           len_next,
    output logic                    dot_next,
    output logic                    ovf_next
);

    localparam logic [LW-1:0] LEN_TOP = LW'(MAX_LEN - 1);

    logic          cont_num;
    logic          cont_id;
    logic          sat;
    logic          dot_after;
    logic [3:0]    open_tt;
    logic [3:0]    char_tt;
    logic [3:0]    op_tt;
    logic [LW+5:0] idx_wide;
    logic [1:0]    k;

    assign cont_num = (mode == etok_pkg::MODE_NUMBER)
                   && (etok_pkg::is_digit(char_byte) || char_byte == etok_pkg::CH_DOT);
    assign cont_id  = (mode == etok_pkg::MODE_IDENT)
                   && (etok_pkg::is_alpha(char_byte) || etok_pkg::is_digit(char_byte)
                       || char_byte == etok_pkg::CH_USCORE);
    assign sat       = (len >= LEN_TOP);
    assign idx_wide  = (LW+6)'(sat ? LEN_TOP : len);
    assign dot_after = dot | (char_byte == etok_pkg::CH_DOT);
    assign open_tt   = (mode == etok_pkg::MODE_NUMBER)
                     ? (dot ? etok_pkg::TT_FLOAT : etok_pkg::TT_INT) : etok_pkg::TT_IDENT;
    assign char_tt   = cont_num ? (dot_after ? etok_pkg::TT_FLOAT : etok_pkg::TT_INT)
                                : etok_pkg::TT_IDENT;
    assign op_tt     = etok_pkg::op_type(char_byte);

    always_comb
    begin
        res[0]    = '0;
        res[1]    = '0;
        res[2]    = '0;
        count     = 2'd0;
        k         = 2'd0;
        mode_next = mode;
        len_next  = len;
        dot_next  = dot;
        ovf_next  = ovf;
        if (cont_num || cont_id)
        begin
            // token continues
            res[0]   = '{etok_pkg::KIND_CHAR, char_tt, char_byte, idx_wide[5:0], 1'b0};
            count    = 2'd1;
            len_next = sat ? len : LW'(len + 1'b1);
            ovf_next = ovf | sat;
            dot_next = cont_num & dot_after;
        end
        else
        begin
            // close any open token, then treat the byte as from idle
            if (mode != etok_pkg::MODE_IDLE)
            begin
                res[0] = '{etok_pkg::KIND_END, open_tt, 8'd0, 6'd0, ovf};
                k      = 2'd1;
            end
            mode_next = etok_pkg::MODE_IDLE;
            len_next  = '0;
            dot_next  = 1'b0;
            ovf_next  = 1'b0;
            count     = k;
            if (char_byte == etok_pkg::CH_NUL)
            begin
                res[k] = '{etok_pkg::KIND_EOI, etok_pkg::TT_INVALID, 8'd0, 6'd0, 1'b0};
                count  = 2'(k + 2'd1);
            end
            else if (char_byte == etok_pkg::CH_SPACE)
            begin
                count = k;
            end
            else if (etok_pkg::is_digit(char_byte))
            begin
                res[k]    = '{etok_pkg::KIND_CHAR, etok_pkg::TT_INT, char_byte, 6'd0, 1'b0};
                count     = 2'(k + 2'd1);
                mode_next = etok_pkg::MODE_NUMBER;
                len_next  = LW'(1);
            end
            else if (etok_pkg::is_alpha(char_byte))
            begin
                res[k]    = '{etok_pkg::KIND_CHAR, etok_pkg::TT_IDENT, char_byte, 6'd0, 1'b0};
                count     = 2'(k + 2'd1);
                mode_next = etok_pkg::MODE_IDENT;
                len_next  = LW'(1);
            end
            else
            begin
                // operator or invalid byte: one-character token
                res[k]            = '{etok_pkg::KIND_CHAR, op_tt, char_byte, 6'd0, 1'b0};
                res[2'(k + 2'd1)] = '{etok_pkg::KIND_END, op_tt, 8'd0, 6'd0, 1'b0};
                count             = 2'(k + 2'd2);
            end
        end
    end

endmodule

[sv/expression_tokenizer.sv]
// expression_tokenizer: a streaming lexer for arithmetic expressions. Each input word is
// one ASCII byte; each result word reports a token character (with its type and index
// within the token), the end of a token (with final type and overflow flag), or the end of
// input on a zero byte. A byte is held in an input register, the lexer step is worked out
// combinationally from it and the token state, and results leave through a result
// register one word per cycle unless result_ready stalls them, so plain token characters
// stream at one byte per cycle when not stalled; a byte that yields several results
// (closing a token and starting an operator, for instance) holds the input register until
// the single result register has issued them all. A byte passes the input register, then
// the result register. Tokens longer than MAX_LEN-1 characters saturate their index and
// report too_long. Depends on etok_pkg and etok_step.

module expression_tokenizer #(
    parameter int MAX_LEN = etok_pkg::MAX_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  logic [7:0] char_byte,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [1:0] kind,
    output logic [3:0] token_type,
    output logic [7:0] char_value,
    output logic [5:0] char_index,
    output logic       too_long,
    output logic       last
);

    localparam int LW = $clog2(MAX_LEN);

    // input register
    logic [7:0]        byte_reg;
    logic              byte_valid_reg;
    logic              byte_valid_next;
    logic [1:0]        res_idx_reg;
    logic [1:0]        res_idx_next;

    // token state
    etok_pkg::mode_t   mode_reg;
    logic [LW-1:0]     len_reg;
    logic              dot_reg;
    logic              ovf_reg;

    etok_pkg::mode_t   mode_step;
    logic [LW-1:0]     len_step;
    logic              dot_step;
    logic              ovf_step;
    etok_pkg::result_t res [3];
    logic [1:0]        count;

    // result register
    etok_pkg::result_t out_reg;
    logic              out_last_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic              out_free;
    logic              issue;
    logic              last_now;
    logic              done;
    logic              take;

    etok_step #(
        .MAX_LEN (MAX_LEN)
    ) u_step (
        .char_byte (byte_reg),
        .mode      (mode_reg),
        .len       (len_reg),
        .dot       (dot_reg),
        .ovf       (ovf_reg),
        .res       (res),
        .count     (count),
        .mode_next (mode_step),
        .len_next  (len_step),
        .dot_next  (dot_step),
        .ovf_next  (ovf_step)
    );

    // handshake and sequencing of the words of one byte
    assign out_free   = !out_valid_reg || result_ready;
    assign issue      = byte_valid_reg && (count != 2'd0) && out_free;
    assign last_now   = (res_idx_reg == 2'(count - 2'd1));
    // byte retires: no word at all (a skipped space) or its final word issued
    assign done       = byte_valid_reg && ((count == 2'd0) || (issue && last_now));
    assign char_ready = !byte_valid_reg || done;
    assign take       = char_valid && char_ready;

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (take)
            byte_valid_next = 1'b1;
        else if (done)
            byte_valid_next = 1'b0;

        res_idx_next = res_idx_reg;
        if (done)
            res_idx_next = 2'd0;
        else if (issue)
            res_idx_next = 2'(res_idx_reg + 2'd1);

        out_valid_next = out_valid_reg;
        if (issue)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            res_idx_reg    <= 2'd0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= etok_pkg::MODE_IDLE;
            len_reg        <= '0;
            dot_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            res_idx_reg    <= res_idx_next;
            out_valid_reg  <= out_valid_next;
            // token state advances only once all words of the byte are out
            if (done)
            begin
                mode_reg <= mode_step;
                len_reg  <= len_step;
                dot_reg  <= dot_step;
                ovf_reg  <= ovf_step;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
            byte_reg <= char_byte;
        if (issue)
        begin
            out_reg      <= res[res_idx_reg];
            out_last_reg <= last_now;
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = out_reg.kind;
    assign token_type   = out_reg.token_type;
    assign char_value   = out_reg.char_value;
    assign char_index   = out_reg.char_index;
    assign too_long     = out_reg.too_long;
    assign last         = out_last_reg;

    // word counter stays inside the words of the held byte
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid_reg && count != 2'd0) |-> (res_idx_reg < count))
        else $error("result index beyond word count");

    // length never passes the saturation point
    a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_LEN - 1))
        else $error("token length above maximum");

    // idle means a fully cleared token
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == etok_pkg::MODE_IDLE) |-> (len_reg == '0 && !dot_reg && !ovf_reg))
        else $error("idle with token state left over");

    // a dot belongs only to a number
    a_dot_number: assert property (@(posedge clk) disable iff (!rst_n)
        dot_reg |-> (mode_reg == etok_pkg::MODE_NUMBER))
        else $error("dot flag outside a number");

    // end of input is always the final word of its byte
    a_eoi_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == etok_pkg::KIND_EOI) |-> out_last_reg)
        else $error("end of input not marked last");

endmodule

[tb/sv/etok_lex_checker.sv]
// checker for the expression tokenizer: watches both word channels, predicts the lexer
// results for every accepted byte and compares them in order; depends on etok_pkg only

module etok_lex_checker
    import etok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    input  logic       char_ready,
    input  logic [7:0] char_byte,
    input  logic       result_valid,
    input  logic       result_ready,
    input  logic [1:0] kind,
    input  logic [3:0] token_type,
    input  logic [7:0] char_value,
    input  logic [5:0] char_index,
    input  logic       too_long,
    input  logic       last,
    output int         fail_count,
    output int         pending_count,
    output int         result_count,
    output int         token_count,
    output int         float_count,
    output int         overflow_count
);

    localparam int TOK_MAX = MAX_LEN_DEF;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] ttype;
        logic [7:0] cval;
        logic [5:0] cidx;
        logic       tl;
        logic       lst;
    } lex_word_t;

    // lexer state as predicted
    mode_t     lex_mode;
    int        tok_len;
    logic      dot_flag;
    logic      ovf_flag;

    lex_word_t token_words_q[$];
    lex_word_t step_words[$];
    int        report_count;

    function automatic logic char_is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic char_is_letter(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
    endfunction

    function automatic logic [3:0] single_type(input logic [7:0] c);
        case (c)
            CH_PLUS:  return TT_PLUS;
            CH_MINUS: return TT_MINUS;
            CH_STAR:  return TT_MUL;
            CH_SLASH: return TT_DIV;
            CH_OPEN:  return TT_OPEN;
            CH_CLOSE: return TT_CLOSE;
            CH_SEMI:  return TT_SEMI;
            default:  return TT_INVALID;
        endcase
    endfunction

    function automatic logic [3:0] open_token_type();
        if (lex_mode == MODE_NUMBER)
            return dot_flag ? TT_FLOAT : TT_INT;
        if (lex_mode == MODE_IDENT)
            return TT_IDENT;
        return TT_INVALID;
    endfunction

    function automatic void emit(input kind_t k, input logic [3:0] t, input logic [7:0] c,
                                 input logic [5:0] i, input logic tl);
        lex_word_t w;
        w.kind  = k;
        w.ttype = t;
        w.cval  = c;
        w.cidx  = i;
        w.tl    = tl;
        w.lst   = 1'b0;
        step_words.push_back(w);
    endfunction

    // index saturates at the last stored position
    task automatic take_char(input logic [7:0] c);
        int idx;
        idx = tok_len;
        if (tok_len >= TOK_MAX - 1)
        begin
            idx      = TOK_MAX - 1;
            ovf_flag = 1'b1;
        end
        else
        begin
            tok_len++;
        end
        emit(KIND_CHAR, open_token_type(), c, 6'(idx), 1'b0);
    endtask

    task automatic lex_byte(input logic [7:0] c);
        step_words.delete();
        if (lex_mode == MODE_NUMBER && (char_is_digit(c) || c == CH_DOT))
        begin
            if (c == CH_DOT)
                dot_flag = 1'b1;
            take_char(c);
        end
        else if (lex_mode == MODE_IDENT &&
                 (char_is_letter(c) || char_is_digit(c) || c == CH_USCORE))
        begin
            take_char(c);
        end
        else
        begin
            if (lex_mode != MODE_IDLE)
                emit(KIND_END, open_token_type(), 8'h00, 6'd0, ovf_flag);
            lex_mode = MODE_IDLE;
            tok_len  = 0;
            dot_flag = 1'b0;
            ovf_flag = 1'b0;
            if (c == CH_NUL)
            begin
                emit(KIND_EOI, TT_INVALID, 8'h00, 6'd0, 1'b0);
            end
            else if (c != CH_SPACE)
            begin
                if (char_is_digit(c))
                begin
                    lex_mode = MODE_NUMBER;
                    take_char(c);
                end
                else if (char_is_letter(c))
                begin
                    lex_mode = MODE_IDENT;
                    take_char(c);
                end
                else
                begin
                    emit(KIND_CHAR, single_type(c), c, 6'd0, 1'b0);
                    emit(KIND_END, single_type(c), 8'h00, 6'd0, 1'b0);
                end
            end
        end
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].lst = 1'b1;
        foreach (step_words[n])
            token_words_q.push_back(step_words[n]);
    endtask

    task automatic check_word();
        lex_word_t got;
        lex_word_t want;
        got = '{kind_t'(kind), token_type, char_value, char_index, too_long, last};
        result_count <= result_count + 1;
        if (token_words_q.size() == 0)
        begin
            fail_count <= fail_count + 1;
            if (report_count < 10)
                $display("unexpected result word: kind=%0d type=%0d char=%02h index=%0d tl=%0b last=%0b",
                         got.kind, got.ttype, got.cval, got.cidx, got.tl, got.lst);
            report_count++;
        end
        else
        begin
            want = token_words_q.pop_front();
            if (got !== want)
            begin
                fail_count <= fail_count + 1;
                if (report_count < 10)
                begin
                    $display("mismatch: expected kind=%0d type=%0d char=%02h index=%0d tl=%0b last=%0b",
                             want.kind, want.ttype, want.cval, want.cidx, want.tl, want.lst);
                    $display("          actual   kind=%0d type=%0d char=%02h index=%0d tl=%0b last=%0b",
                             got.kind, got.ttype, got.cval, got.cidx, got.tl, got.lst);
                end
                report_count++;
            end
            else if (want.kind == KIND_END)
            begin
                token_count <= token_count + 1;
                if (want.ttype == TT_FLOAT)
                    float_count <= float_count + 1;
                if (want.tl)
                    overflow_count <= overflow_count + 1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_mode       = MODE_IDLE;
            tok_len        = 0;
            dot_flag       = 1'b0;
            ovf_flag       = 1'b0;
            report_count   = 0;
            token_words_q.delete();
            fail_count     <= 0;
            pending_count  <= 0;
            result_count   <= 0;
            token_count    <= 0;
            float_count    <= 0;
            overflow_count <= 0;
        end
        else
        begin
            if (char_valid && char_ready)
                lex_byte(char_byte);
            if (result_valid && result_ready)
                check_word();
            pending_count <= token_words_q.size();
        end
    end

endmodule

[tb/sv/tb_expression_tokenizer.sv]
// top of the expression tokenizer testbench: clock, reset, byte stimulus and result stalls
// depends on etok_pkg, expression_tokenizer and etok_lex_checker

module tb_expression_tokenizer;
    import etok_pkg::*;

    // far above the slowest legal run of a few hundred words
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 185;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       char_valid   = 1'b0;
    logic [7:0] char_byte    = 8'h00;
    logic       result_ready = 1'b0;
    // set during the stretch where neither side idles
    logic       no_idle      = 1'b0;

    logic       char_ready;
    logic       result_valid;
    logic [1:0] kind;
    logic [3:0] token_type;
    logic [7:0] char_value;
    logic [5:0] char_index;
    logic       too_long;
    logic       last;

    int fail_count;
    int pending_count;
    int result_count;
    int token_count;
    int float_count;
    int overflow_count;

    int    words_sent  = 0;
    int    cycle_count = 0;
    int    start_words;
    int    rel;
    int    roll;
    bit    long_ident_done;
    bit    long_number_done;
    bit    paused;
    // directed opening: float, identifier with underscore and digit, a space close,
    // an identifier closed by an operator (three results), and every operator
    string directed = "0.9+a_Z9 (zA)*-/;";

    always #5 clk = ~clk;

    expression_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_byte    (char_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .token_type   (token_type),
        .char_value   (char_value),
        .char_index   (char_index),
        .too_long     (too_long),
        .last         (last)
    );

    etok_lex_checker lex_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_ready     (char_ready),
        .char_byte      (char_byte),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .kind           (kind),
        .token_type     (token_type),
        .char_value     (char_value),
        .char_index     (char_index),
        .too_long       (too_long),
        .last           (last),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .result_count   (result_count),
        .token_count    (token_count),
        .float_count    (float_count),
        .overflow_count (overflow_count)
    );

    // receiver stalls with a probability of about 18 percent, none in the quiet stretch
    always @(posedge clk)
        result_ready <= no_idle || ($urandom_range(0, 99) >= 18);

    // one byte word: random gaps with valid low, then hold valid until accepted
    task automatic send_word(input logic [7:0] b);
        while (!no_idle && $urandom_range(0, 99) < 18)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_byte  <= b;
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // lower valid and wait until every predicted result word has been seen;
    // the first edge lets the checker count the word accepted last
    task automatic drain_results();
        char_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0)
            return 8'h41 + 8'($urandom_range(0, 25));
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(0, 6))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4:       return CH_OPEN;
            5:       return CH_CLOSE;
            default: return CH_SEMI;
        endcase
    endfunction

    // digits with an occasional dot after the first one, so some numbers end as float
    task automatic send_number(input int len);
        for (int i = 0; i < len; i++)
        begin
            if (i > 0 && $urandom_range(0, 4) == 0)
                send_word(CH_DOT);
            else
                send_word(rand_digit());
        end
    endtask

    // letter first, then letters, digits and underscores
    task automatic send_ident(input int len);
        int pick;
        send_word(rand_letter());
        for (int i = 1; i < len; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                send_word(rand_letter());
            else if (pick < 9)
                send_word(rand_digit());
            else
                send_word(CH_USCORE);
        end
    endtask

    // token at the length limit: exactly full, one over, or three over
    task automatic send_long(input bit as_number);
        int len;
        case ($urandom_range(0, 2))
            0:       len = MAX_LEN_DEF - 1;
            1:       len = MAX_LEN_DEF;
            default: len = MAX_LEN_DEF + 2;
        endcase
        if (as_number)
            send_number(len);
        else
            send_ident(len);
    endtask

    // run limit, counted in clock cycles
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run hit the cycle limit of %0d", CYCLE_LIMIT);
        $display("tb_expression_tokenizer: errors");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: opening string, then byte extremes, a lone underscore,
        // a control byte and a number closed by end of input
        for (int i = 0; i < directed.len(); i++)
            send_word(directed[i]);
        send_word(8'hFF);
        send_word(8'h80);
        send_word(8'h7F);
        send_word(CH_USCORE);
        send_word(8'h01);
        send_word(8'h35);
        send_word(CH_NUL);

        // random part: mostly expression pieces, some noise and early end of input
        start_words      = words_sent;
        long_ident_done  = 1'b0;
        long_number_done = 1'b0;
        paused           = 1'b0;
        rel              = 0;
        while (rel < RANDOM_WORDS)
        begin
            no_idle <= (rel >= 80 && rel < 125);
            if (!long_ident_done && rel >= 10)
            begin
                send_long(1'b0);
                long_ident_done = 1'b1;
            end
            else if (!paused && rel >= 75)
            begin
                // sender holds off until the result side has caught up
                drain_results();
                paused = 1'b1;
            end
            else if (!long_number_done && rel >= 125)
            begin
                send_long(1'b1);
                long_number_done = 1'b1;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 30)
                    send_number($urandom_range(1, 5));
                else if (roll < 55)
                    send_ident($urandom_range(1, 6));
                else if (roll < 78)
                    send_word(rand_operator());
                else if (roll < 88)
                    send_word(CH_SPACE);
                else if (roll < 96)
                    send_word(8'($urandom_range(1, 255)));
                else
                    send_word(CH_NUL);
            end
            rel = words_sent - start_words;
        end

        // close any open token so its end word is checked too
        send_word(CH_NUL);
        drain_results();
        repeat (20) @(posedge clk);

        $display("covered %0d byte words and %0d result words: %0d tokens, %0d float, %0d over length",
                 words_sent, result_count, token_count, float_count, overflow_count);
        if (pending_count != 0)
            $display("result words still expected at the end: %0d", pending_count);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_expression_tokenizer: clean");
        else
            $display("tb_expression_tokenizer: errors");
        $finish;
    end

endmodule

[expression_tokenizer.f]
sv/etok_pkg.sv
sv/etok_step.sv
sv/expression_tokenizer.sv
tb/sv/etok_lex_checker.sv
tb/sv/tb_expression_tokenizer.sv
